>>> sv/stack_machine_execute_unit_assert.svh
// Assertion macros used by the stack machine execute unit RTL.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define SMEU_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("smeu invariant violated");
// An implication whose consequent is checked in the cycle after the antecedent.
`define SMEU_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("smeu sequence violated");
`else
`define SMEU_ASSERT(lbl, cond)
`define SMEU_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> sv/smeu_pkg.sv
// Types, codes and default sizes for the stack machine execute unit.
`timescale 1ns / 1ps
package smeu_pkg;

	// Default sizes.
	localparam int STACK_DEPTH    = 64;
	localparam int CALL_DEPTH     = 16;
	localparam int REGISTER_COUNT = 8;
	localparam int INDEX_WIDTH    = 16;

	// Field widths of the words on the two channels.
	localparam int FUNC_W   = 5;
	localparam int DATA_W   = 64;
	localparam int REG_W    = 3;
	localparam int FIELD_IW = 16;
	localparam int STATUS_W = 3;

	// Opcodes.
	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH    = 5'd0,
		OP_PUSHREG = 5'd1,
		OP_POPREG  = 5'd2,
		OP_ADD     = 5'd3,
		OP_SUB     = 5'd4,
		OP_MUL     = 5'd5,
		OP_DIV     = 5'd6,
		OP_SQRT    = 5'd7,
		OP_OUT     = 5'd8,
		OP_JMP     = 5'd9,
		OP_JB      = 5'd10,
		OP_JBE     = 5'd11,
		OP_JE      = 5'd12,
		OP_JNE     = 5'd13,
		OP_JA      = 5'd14,
		OP_JAE     = 5'd15,
		OP_CALL    = 5'd16,
		OP_RET     = 5'd17
	} op_t;

	// Status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_DIV_ZERO  = 3'd3,
		ST_NEG_SQRT  = 3'd4,
		ST_RET_ERR   = 3'd5
	} status_t;

	// Operations of the shared multi-cycle arithmetic unit.
	typedef enum logic [1:0] {
		ITER_MUL  = 2'd0,
		ITER_DIV  = 2'd1,
		ITER_SQRT = 2'd2
	} iter_op_t;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_req_t;

endpackage

>>> sv/smeu_if.sv
// Valid/ready channel interfaces for instruction and result words.
`timescale 1ns / 1ps
interface smeu_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [smeu_pkg::FUNC_W-1:0]          func;
	logic signed [smeu_pkg::DATA_W-1:0]   push_value;
	logic [smeu_pkg::REG_W-1:0]           reg_index;
	logic [smeu_pkg::FIELD_IW-1:0]        target;
	logic [smeu_pkg::FIELD_IW-1:0]        instr_index;

	modport source (output valid, func, push_value, reg_index, target, instr_index,
		input ready);
	modport sink (input valid, func, push_value, reg_index, target, instr_index,
		output ready);
endinterface

interface smeu_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [smeu_pkg::FIELD_IW-1:0]        next_index;
	logic                                 jump_taken;
	logic signed [smeu_pkg::DATA_W-1:0]   top_value;
	logic                                 top_valid;
	logic [smeu_pkg::STATUS_W-1:0]        status;

	modport source (output valid, next_index, jump_taken, top_value, top_valid, status,
		input ready);
	modport sink (input valid, next_index, jump_taken, top_value, top_valid, status,
		output ready);
endinterface

>>> sv/smeu_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
`timescale 1ns / 1ps
module smeu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/smeu_iter.sv
// Shared multi-cycle unit: 64-bit multiply, signed divide and integer square root.
`timescale 1ns / 1ps
module smeu_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  smeu_pkg::iter_req_t req,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	output logic                done,
	output logic [63:0]         result
);

	logic                 busy_q;
	logic                 done_q;
	smeu_pkg::iter_op_t   op_q;
	logic [6:0]           cnt_q;
	logic                 neg_q;
	logic [63:0]          x_q;
	logic [63:0]          y_q;
	logic [64:0]          r_q;
	logic [63:0]          q_q;

	logic [64:0] div_rs;
	logic [34:0] sq_rs;
	logic [34:0] sq_trial;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	// Step datapaths: one quotient bit, one root bit, or one partial product.
	always_comb begin
		div_rs   = {r_q[63:0], x_q[63]};
		sq_rs    = {r_q[32:0], x_q[63:62]};
		sq_trial = {1'b0, q_q[31:0], 2'b01};
		mul_a    = (cnt_q == 7'd0) ? x_q[63:32] : x_q[31:0];
		mul_b    = (cnt_q == 7'd1) ? y_q[63:32] : y_q[31:0];
		mul_p    = 64'(mul_a) * 64'(mul_b);
	end

	// Control and operand registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= smeu_pkg::ITER_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				unique case (req.op)
					smeu_pkg::ITER_DIV:  cnt_q <= 7'd63;
					smeu_pkg::ITER_SQRT: cnt_q <= 7'd31;
					default:             cnt_q <= 7'd2;
				endcase
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= '0;
			q_q   <= '0;
			neg_q <= a[63] ^ b[63];
			if (req.op == smeu_pkg::ITER_DIV) begin
				x_q <= a[63] ? (64'd0 - a) : a;
				y_q <= b[63] ? (64'd0 - b) : b;
			end else begin
				x_q <= a;
				y_q <= b;
			end
		end else if (busy_q) begin
			unique case (op_q)
				smeu_pkg::ITER_DIV: begin
					x_q <= {x_q[62:0], 1'b0};
					if (div_rs >= {1'b0, y_q}) begin
						r_q <= div_rs - {1'b0, y_q};
						q_q <= {q_q[62:0], 1'b1};
					end else begin
						r_q <= div_rs;
						q_q <= {q_q[62:0], 1'b0};
					end
				end
				smeu_pkg::ITER_SQRT: begin
					x_q <= {x_q[61:0], 2'b00};
					if (sq_rs >= sq_trial) begin
						r_q <= 65'(sq_rs - sq_trial);
						q_q <= {q_q[62:0], 1'b1};
					end else begin
						r_q <= 65'(sq_rs);
						q_q <= {q_q[62:0], 1'b0};
					end
				end
				default: begin
					if (cnt_q == 7'd2) begin
						q_q <= mul_p;
					end else begin
						q_q <= q_q + {mul_p[31:0], 32'd0};
					end
				end
			endcase
		end
	end

	// Quotient sign is applied on the way out.
	assign done   = done_q;
	assign result = (op_q == smeu_pkg::ITER_DIV && neg_q) ? (64'd0 - q_q) : q_q;

endmodule

>>> sv/stack_machine_execute_unit.sv
// Stack machine execute unit: runs one instruction per instruction word and returns one
// result word with the next instruction index, the top of the data stack and a status.
// The top of the data stack is held in a register; the entries below it and the return
// stack live in synchronous RAMs whose read data is ready in the cycle after the word is
// accepted. Push, pop, add, sub, peek, jump, call and return go through the execute state
// to the result register; conditional jumps add a second RAM read that fetches the new
// top; multiply, square root and divide wait on the shared one-step-per-cycle arithmetic
// unit. One instruction is in flight at a time; a new word is taken once the previous
// result is in the output register. No clearing pass runs after reset.
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_assert.svh"
module stack_machine_execute_unit #(
	parameter int STACK_DEPTH    = smeu_pkg::STACK_DEPTH,
	parameter int CALL_DEPTH     = smeu_pkg::CALL_DEPTH,
	parameter int REGISTER_COUNT = smeu_pkg::REGISTER_COUNT,
	parameter int INDEX_WIDTH    = smeu_pkg::INDEX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	smeu_cmd_if.sink    cmd,
	smeu_rsp_if.source  rsp
);

	localparam int DC_W = $clog2(STACK_DEPTH + 1);
	localparam int DA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int RC_W = $clog2(CALL_DEPTH + 1);
	localparam int RA_W = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int FA_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
	localparam int FX_W = ((FA_W > smeu_pkg::REG_W) ? FA_W : smeu_pkg::REG_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_ITER = 5'b00100,
		S_POP2 = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                    state_q;
	logic [DC_W-1:0]           dcount_q;
	logic [RC_W-1:0]           rcount_q;
	logic [63:0]               top_q;
	logic [63:0]               rf_q [REGISTER_COUNT];

	// Latched instruction word.
	smeu_pkg::op_t             func_q;
	logic [63:0]               pval_q;
	logic [smeu_pkg::REG_W-1:0] reg_q;
	logic [INDEX_WIDTH-1:0]    target_q;
	logic [INDEX_WIDTH-1:0]    here_q;

	// Pending result fields.
	logic [INDEX_WIDTH-1:0]    nxt_q;
	logic                      taken_q;
	smeu_pkg::status_t         status_q;

	// Output register.
	logic                      ovalid_q;
	logic [smeu_pkg::FIELD_IW-1:0] onext_q;
	logic                      otaken_q;
	logic [63:0]               otop_q;
	logic                      otopv_q;
	logic [smeu_pkg::STATUS_W-1:0] ostatus_q;

	// Memory ports.
	logic                      ds_we;
	logic [DA_W-1:0]           ds_waddr;
	logic [DA_W-1:0]           ds_raddr;
	logic [63:0]               ds_rdata;
	logic                      rs_we;
	logic [RA_W-1:0]           rs_waddr;
	logic [RA_W-1:0]           rs_raddr;
	logic [INDEX_WIDTH-1:0]    rs_rdata;

	// Arithmetic unit.
	smeu_pkg::iter_req_t       ireq;
	logic                      idone;
	logic [63:0]               ires;

	// Decode helpers.
	logic [FX_W-1:0]           reg_x;
	logic [FA_W-1:0]           rf_addr;
	logic                      reg_ok;
	logic                      two_ok;
	logic                      full;
	logic                      cond;
	logic                      out_free;
	logic [DC_W-1:0]           rd_off;
	logic [DC_W-1:0]           rd_ptr;
	logic [DC_W-1:0]           wr_ptr;
	logic [RC_W-1:0]           rret_ptr;

	assign cmd.ready = (state_q == S_IDLE);
	assign out_free  = !ovalid_q || rsp.ready;

	always_comb begin
		reg_x   = FX_W'(reg_q);
		rf_addr = reg_x[FA_W-1:0];
		reg_ok  = reg_x < FX_W'(REGISTER_COUNT);
		two_ok  = dcount_q >= DC_W'(2);
		full    = dcount_q == DC_W'(STACK_DEPTH);
	end

	// Data stack read: the word below the top on acceptance, the one below that
	// while a conditional jump pops two.
	always_comb begin
		rd_off   = (state_q == S_EXEC) ? DC_W'(3) : DC_W'(2);
		rd_ptr   = dcount_q - rd_off;
		ds_raddr = rd_ptr[DA_W-1:0];
		wr_ptr   = dcount_q - DC_W'(1);
		ds_waddr = wr_ptr[DA_W-1:0];
		ds_we    = (state_q == S_EXEC) && !full && (dcount_q != '0)
			&& (func_q == smeu_pkg::OP_PUSH || func_q == smeu_pkg::OP_PUSHREG);
	end

	// Return stack: read the last saved index, write at the fill count on a call.
	always_comb begin
		rret_ptr = rcount_q - RC_W'(1);
		rs_raddr = rret_ptr[RA_W-1:0];
		rs_waddr = rcount_q[RA_W-1:0];
		rs_we    = (state_q == S_EXEC) && (func_q == smeu_pkg::OP_CALL)
			&& (rcount_q != RC_W'(CALL_DEPTH));
	end

	// Launch of multi-cycle arithmetic.
	always_comb begin
		ireq.start = 1'b0;
		ireq.op    = smeu_pkg::ITER_MUL;
		if (state_q == S_EXEC) begin
			unique case (func_q)
				smeu_pkg::OP_MUL: begin
					ireq.start = two_ok;
				end
				smeu_pkg::OP_DIV: begin
					ireq.start = two_ok && (top_q != '0);
					ireq.op    = smeu_pkg::ITER_DIV;
				end
				smeu_pkg::OP_SQRT: begin
					ireq.start = (dcount_q != '0) && !top_q[63];
					ireq.op    = smeu_pkg::ITER_SQRT;
				end
				default: begin
					ireq.start = 1'b0;
				end
			endcase
		end
	end

	// Signed compare of the two popped words: below against top.
	always_comb begin
		unique case (func_q)
			smeu_pkg::OP_JB:  cond = $signed(ds_rdata) < $signed(top_q);
			smeu_pkg::OP_JBE: cond = !($signed(top_q) < $signed(ds_rdata));
			smeu_pkg::OP_JE:  cond = ds_rdata == top_q;
			smeu_pkg::OP_JNE: cond = ds_rdata != top_q;
			smeu_pkg::OP_JA:  cond = $signed(top_q) < $signed(ds_rdata);
			default:          cond = !($signed(ds_rdata) < $signed(top_q));
		endcase
	end

	smeu_ram #(
		.WIDTH (64),
		.DEPTH (STACK_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (ds_we),
		.waddr (ds_waddr),
		.wdata (top_q),
		.raddr (ds_raddr),
		.rdata (ds_rdata)
	);

	smeu_ram #(
		.WIDTH (INDEX_WIDTH),
		.DEPTH (CALL_DEPTH)
	) u_ret_ram (
		.clk   (clk),
		.we    (rs_we),
		.waddr (rs_waddr),
		.wdata (here_q),
		.raddr (rs_raddr),
		.rdata (rs_rdata)
	);

	smeu_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ireq),
		.a      ((func_q == smeu_pkg::OP_SQRT) ? top_q : ds_rdata),
		.b      (top_q),
		.done   (idone),
		.result (ires)
	);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dcount_q <= '0;
			rcount_q <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			// The output register refills as it drains, or empties once taken.
			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					unique case (func_q)
						smeu_pkg::OP_PUSH, smeu_pkg::OP_PUSHREG: begin
							if (!full) begin
								dcount_q <= dcount_q + DC_W'(1);
							end
						end
						smeu_pkg::OP_POPREG: begin
							if (dcount_q != '0) begin
								dcount_q <= dcount_q - DC_W'(1);
								if (reg_ok) begin
									rf_q[rf_addr] <= top_q;
								end
							end
						end
						smeu_pkg::OP_ADD, smeu_pkg::OP_SUB: begin
							if (two_ok) begin
								dcount_q <= dcount_q - DC_W'(1);
							end
						end
						smeu_pkg::OP_MUL, smeu_pkg::OP_DIV, smeu_pkg::OP_SQRT: begin
							if (ireq.start) begin
								state_q <= S_ITER;
							end
						end
						smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JE,
						smeu_pkg::OP_JNE, smeu_pkg::OP_JA, smeu_pkg::OP_JAE: begin
							if (two_ok) begin
								dcount_q <= dcount_q - DC_W'(2);
								state_q  <= S_POP2;
							end
						end
						smeu_pkg::OP_CALL: begin
							if (rs_we) begin
								rcount_q <= rcount_q + RC_W'(1);
							end
						end
						smeu_pkg::OP_RET: begin
							if (rcount_q != '0) begin
								rcount_q <= rcount_q - RC_W'(1);
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_ITER: begin
					if (idone) begin
						state_q <= S_DONE;
						if (func_q != smeu_pkg::OP_SQRT) begin
							dcount_q <= dcount_q - DC_W'(1);
						end
					end
				end
				S_POP2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: instruction word, top of stack and pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					func_q   <= smeu_pkg::op_t'(cmd.func);
					pval_q   <= cmd.push_value;
					reg_q    <= cmd.reg_index;
					target_q <= INDEX_WIDTH'(cmd.target);
					here_q   <= INDEX_WIDTH'(cmd.instr_index);
				end
			end
			S_EXEC: begin
				nxt_q    <= here_q;
				taken_q  <= 1'b0;
				status_q <= smeu_pkg::ST_OK;
				unique case (func_q)
					smeu_pkg::OP_PUSH: begin
						if (full) status_q <= smeu_pkg::ST_OVERFLOW;
						else top_q <= pval_q;
					end
					smeu_pkg::OP_PUSHREG: begin
						if (full) status_q <= smeu_pkg::ST_OVERFLOW;
						else top_q <= reg_ok ? rf_q[rf_addr] : 64'd0;
					end
					smeu_pkg::OP_POPREG: begin
						if (dcount_q == '0) status_q <= smeu_pkg::ST_UNDERFLOW;
						else top_q <= ds_rdata;
					end
					smeu_pkg::OP_SQRT: begin
						if (dcount_q == '0) status_q <= smeu_pkg::ST_UNDERFLOW;
						else if (top_q[63]) status_q <= smeu_pkg::ST_NEG_SQRT;
					end
					smeu_pkg::OP_OUT: begin
						if (dcount_q == '0) status_q <= smeu_pkg::ST_UNDERFLOW;
					end
					smeu_pkg::OP_ADD: begin
						if (!two_ok) status_q <= smeu_pkg::ST_UNDERFLOW;
						else top_q <= ds_rdata + top_q;
					end
					smeu_pkg::OP_SUB: begin
						if (!two_ok) status_q <= smeu_pkg::ST_UNDERFLOW;
						else top_q <= ds_rdata - top_q;
					end
					smeu_pkg::OP_MUL: begin
						if (!two_ok) status_q <= smeu_pkg::ST_UNDERFLOW;
					end
					smeu_pkg::OP_DIV: begin
						if (!two_ok) status_q <= smeu_pkg::ST_UNDERFLOW;
						else if (top_q == '0) status_q <= smeu_pkg::ST_DIV_ZERO;
					end
					smeu_pkg::OP_JMP: begin
						nxt_q   <= target_q;
						taken_q <= 1'b1;
					end
					smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JE,
					smeu_pkg::OP_JNE, smeu_pkg::OP_JA, smeu_pkg::OP_JAE: begin
						if (!two_ok) begin
							status_q <= smeu_pkg::ST_UNDERFLOW;
						end else if (cond) begin
							nxt_q   <= target_q;
							taken_q <= 1'b1;
						end
					end
					smeu_pkg::OP_CALL: begin
						if (!rs_we) begin
							status_q <= smeu_pkg::ST_RET_ERR;
						end else begin
							nxt_q   <= target_q;
							taken_q <= 1'b1;
						end
					end
					smeu_pkg::OP_RET: begin
						if (rcount_q == '0) begin
							status_q <= smeu_pkg::ST_RET_ERR;
						end else begin
							nxt_q   <= rs_rdata;
							taken_q <= 1'b1;
						end
					end
					default: begin
						status_q <= smeu_pkg::ST_OK;
					end
				endcase
			end
			S_ITER: begin
				if (idone) top_q <= ires;
			end
			S_POP2: begin
				top_q <= ds_rdata;
			end
			S_DONE: begin
				if (out_free) begin
					onext_q   <= smeu_pkg::FIELD_IW'(nxt_q);
					otaken_q  <= taken_q;
					otop_q    <= (dcount_q != '0) ? top_q : 64'd0;
					otopv_q   <= dcount_q != '0;
					ostatus_q <= status_q;
				end
			end
			default: begin
				top_q <= top_q;
			end
		endcase
	end

	// Result channel.
	assign rsp.valid      = ovalid_q;
	assign rsp.next_index = onext_q;
	assign rsp.jump_taken = otaken_q;
	assign rsp.top_value  = otop_q;
	assign rsp.top_valid  = otopv_q;
	assign rsp.status     = ostatus_q;

	// Checks on the sequencer and the stack fill counts.
	`SMEU_ASSERT(a_dcount_range, dcount_q <= DC_W'(STACK_DEPTH))
	`SMEU_ASSERT(a_rcount_range, rcount_q <= RC_W'(CALL_DEPTH))
	`SMEU_ASSERT(a_iter_start_exec, !ireq.start || state_q == S_EXEC)
	`SMEU_ASSERT(a_iter_done_wait, !idone || state_q == S_ITER)
	`SMEU_ASSERT(a_fault_no_jump, !(ovalid_q && otaken_q && ostatus_q != smeu_pkg::ST_OK))
	`SMEU_ASSERT_NEXT(a_exec_follows_accept, cmd.valid && cmd.ready, state_q == S_EXEC)

endmodule

>>> verif/tb.sv
// Self-checking testbench for the stack machine execute unit.
`timescale 1ns / 1ps
module tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_WORDS   = 1700;

	typedef struct {
		logic [smeu_pkg::FUNC_W-1:0]   func;
		logic [smeu_pkg::DATA_W-1:0]   value;
		logic [smeu_pkg::REG_W-1:0]    ridx;
		logic [smeu_pkg::FIELD_IW-1:0] dest;
		logic [smeu_pkg::FIELD_IW-1:0] here;
	} instr_t;

	typedef struct {
		logic [smeu_pkg::FIELD_IW-1:0] next_index;
		logic                          jump_taken;
		logic [smeu_pkg::DATA_W-1:0]   top_value;
		logic                          top_valid;
		logic [smeu_pkg::STATUS_W-1:0] status;
	} outcome_t;

	logic clk;
	logic arst_n;

	smeu_cmd_if cmd ();
	smeu_rsp_if rsp ();

	stack_machine_execute_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	instr_t   pending_instrs[$];
	outcome_t awaited_outcomes[$];
	int       mismatches = 0;
	int       accepted_instrs = 0;
	int       idle_cycles;
	int       pending_total = 1;

	// Machine state as the predictor sees it.
	logic [smeu_pkg::DATA_W-1:0]      mdl_data[smeu_pkg::STACK_DEPTH];
	int                               mdl_dcount = 0;
	logic [smeu_pkg::INDEX_WIDTH-1:0] mdl_ret[smeu_pkg::CALL_DEPTH];
	int                               mdl_rcount = 0;
	logic [smeu_pkg::DATA_W-1:0]      mdl_regs[smeu_pkg::REGISTER_COUNT] = '{default: '0};

	// Rough depths used only to steer the random instruction mix.
	int gen_dcount;
	int gen_rcount;

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [smeu_pkg::DATA_W-1:0] floor_sqrt(
		logic [smeu_pkg::DATA_W-1:0] v);
		logic [smeu_pkg::DATA_W-1:0] res;
		logic [smeu_pkg::DATA_W-1:0] bitv;
		res  = '0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [smeu_pkg::DATA_W-1:0] trunc_div(logic [smeu_pkg::DATA_W-1:0] a,
		logic [smeu_pkg::DATA_W-1:0] b);
		logic [smeu_pkg::DATA_W-1:0] ma;
		logic [smeu_pkg::DATA_W-1:0] mb;
		logic [smeu_pkg::DATA_W-1:0] q;
		ma = a[smeu_pkg::DATA_W-1] ? -a : a;
		mb = b[smeu_pkg::DATA_W-1] ? -b : b;
		q  = ma / mb;
		return (a[smeu_pkg::DATA_W-1] != b[smeu_pkg::DATA_W-1]) ? -q : q;
	endfunction

	// Executes one instruction on the predictor state and gives the result word.
	function automatic outcome_t execute_instr(instr_t w);
		outcome_t                    o;
		logic [smeu_pkg::DATA_W-1:0] a;
		logic [smeu_pkg::DATA_W-1:0] b;
		logic [smeu_pkg::DATA_W-1:0] r;
		logic                        cond;
		o.next_index = w.here;
		o.jump_taken = 1'b0;
		o.status     = smeu_pkg::ST_OK;
		case (w.func)
			smeu_pkg::OP_PUSH, smeu_pkg::OP_PUSHREG: begin
				if (mdl_dcount >= smeu_pkg::STACK_DEPTH) begin
					o.status = smeu_pkg::ST_OVERFLOW;
				end else begin
					r = w.value;
					if (w.func == smeu_pkg::OP_PUSHREG)
						r = (w.ridx < smeu_pkg::REGISTER_COUNT) ? mdl_regs[w.ridx] : '0;
					mdl_data[mdl_dcount] = r;
					mdl_dcount++;
				end
			end
			smeu_pkg::OP_POPREG, smeu_pkg::OP_SQRT, smeu_pkg::OP_OUT: begin
				if (mdl_dcount == 0) begin
					o.status = smeu_pkg::ST_UNDERFLOW;
				end else if (w.func == smeu_pkg::OP_POPREG) begin
					mdl_dcount--;
					if (w.ridx < smeu_pkg::REGISTER_COUNT)
						mdl_regs[w.ridx] = mdl_data[mdl_dcount];
				end else if (w.func == smeu_pkg::OP_SQRT) begin
					if (mdl_data[mdl_dcount-1][smeu_pkg::DATA_W-1])
						o.status = smeu_pkg::ST_NEG_SQRT;
					else
						mdl_data[mdl_dcount-1] = floor_sqrt(mdl_data[mdl_dcount-1]);
				end
			end
			smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
				if (mdl_dcount < 2) begin
					o.status = smeu_pkg::ST_UNDERFLOW;
				end else begin
					b = mdl_data[mdl_dcount-1];
					a = mdl_data[mdl_dcount-2];
					r = '0;
					case (w.func)
						smeu_pkg::OP_ADD: r = a + b;
						smeu_pkg::OP_SUB: r = a - b;
						smeu_pkg::OP_MUL: r = a * b;
						default: begin
							if (b == 0)
								o.status = smeu_pkg::ST_DIV_ZERO;
							else
								r = trunc_div(a, b);
						end
					endcase
					if (o.status == smeu_pkg::ST_OK) begin
						mdl_dcount--;
						mdl_data[mdl_dcount-1] = r;
					end
				end
			end
			smeu_pkg::OP_JMP: begin
				o.next_index = w.dest;
				o.jump_taken = 1'b1;
			end
			smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JE,
			smeu_pkg::OP_JNE, smeu_pkg::OP_JA, smeu_pkg::OP_JAE: begin
				if (mdl_dcount < 2) begin
					o.status = smeu_pkg::ST_UNDERFLOW;
				end else begin
					b = mdl_data[mdl_dcount-1];
					a = mdl_data[mdl_dcount-2];
					mdl_dcount -= 2;
					case (w.func)
						smeu_pkg::OP_JB:  cond = $signed(a) < $signed(b);
						smeu_pkg::OP_JBE: cond = $signed(a) <= $signed(b);
						smeu_pkg::OP_JE:  cond = a == b;
						smeu_pkg::OP_JNE: cond = a != b;
						smeu_pkg::OP_JA:  cond = $signed(a) > $signed(b);
						default:          cond = $signed(a) >= $signed(b);
					endcase
					if (cond) begin
						o.next_index = w.dest;
						o.jump_taken = 1'b1;
					end
				end
			end
			smeu_pkg::OP_CALL: begin
				if (mdl_rcount >= smeu_pkg::CALL_DEPTH) begin
					o.status = smeu_pkg::ST_RET_ERR;
				end else begin
					mdl_ret[mdl_rcount] = w.here;
					mdl_rcount++;
					o.next_index = w.dest;
					o.jump_taken = 1'b1;
				end
			end
			smeu_pkg::OP_RET: begin
				if (mdl_rcount == 0) begin
					o.status = smeu_pkg::ST_RET_ERR;
				end else begin
					mdl_rcount--;
					o.next_index = mdl_ret[mdl_rcount];
					o.jump_taken = 1'b1;
				end
			end
			default: ;
		endcase
		o.top_valid = mdl_dcount > 0;
		o.top_value = (mdl_dcount > 0) ? mdl_data[mdl_dcount-1] : '0;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [smeu_pkg::DATA_W-1:0] got,
		logic [smeu_pkg::DATA_W-1:0] want);
		$display("MISMATCH %s: got %h, want %h (word %0d)", what, got, want, accepted_instrs);
		mismatches++;
	endtask

	function automatic logic [smeu_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 64'($urandom_range(0, 3));
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'h8000_0000_0000_0000;
			3: return {$urandom, $urandom};
			4: return 64'($signed($urandom_range(0, 8)) - 4);
			default: return {32'h0, $urandom};
		endcase
	endfunction

	// Queues one instruction and tracks the approximate stack depths.
	task automatic queue_instr(logic [smeu_pkg::FUNC_W-1:0] f, logic [smeu_pkg::DATA_W-1:0] v,
		logic [smeu_pkg::REG_W-1:0] ri);
		instr_t w;
		w.func  = f;
		w.value = v;
		w.ridx  = ri;
		w.dest  = 16'($urandom);
		w.here  = 16'($urandom);
		pending_instrs.push_back(w);
		case (f)
			smeu_pkg::OP_PUSH, smeu_pkg::OP_PUSHREG:
				if (gen_dcount < smeu_pkg::STACK_DEPTH) gen_dcount++;
			smeu_pkg::OP_POPREG: if (gen_dcount > 0) gen_dcount--;
			smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV:
				if (gen_dcount >= 2) gen_dcount--;
			smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JE,
			smeu_pkg::OP_JNE, smeu_pkg::OP_JA, smeu_pkg::OP_JAE:
				if (gen_dcount >= 2) gen_dcount -= 2;
			smeu_pkg::OP_CALL: if (gen_rcount < smeu_pkg::CALL_DEPTH) gen_rcount++;
			smeu_pkg::OP_RET: if (gen_rcount > 0) gen_rcount--;
			default: ;
		endcase
	endtask

	task automatic queue_random_instr();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 1) begin
			// Fill the data stack past its depth.
			n = smeu_pkg::STACK_DEPTH - gen_dcount + 2;
			repeat (n) queue_instr(smeu_pkg::OP_PUSH, pick_value(), 3'($urandom));
		end else if (r < 2) begin
			// Nest calls past the return stack depth, then unwind past empty.
			repeat (smeu_pkg::CALL_DEPTH - gen_rcount + 1)
				queue_instr(smeu_pkg::OP_CALL, pick_value(), 3'($urandom));
			repeat (smeu_pkg::CALL_DEPTH + 1)
				queue_instr(smeu_pkg::OP_RET, pick_value(), 3'($urandom));
		end else if (r < 30 || gen_dcount < 2) begin
			if (gen_dcount > 56)
				queue_instr(smeu_pkg::OP_POPREG, pick_value(), 3'($urandom));
			else
				queue_instr(($urandom_range(0, 3) == 0) ? smeu_pkg::OP_PUSHREG
					: smeu_pkg::OP_PUSH, pick_value(), 3'($urandom));
		end else if (r < 38) begin
			queue_instr(smeu_pkg::OP_POPREG, pick_value(), 3'($urandom));
		end else if (r < 56) begin
			queue_instr(5'($urandom_range(smeu_pkg::OP_ADD, smeu_pkg::OP_DIV)), pick_value(),
				3'($urandom));
		end else if (r < 60) begin
			queue_instr(smeu_pkg::OP_SQRT, pick_value(), 3'($urandom));
		end else if (r < 64) begin
			queue_instr(smeu_pkg::OP_OUT, pick_value(), 3'($urandom));
		end else if (r < 67) begin
			queue_instr(smeu_pkg::OP_JMP, pick_value(), 3'($urandom));
		end else if (r < 82) begin
			queue_instr(5'($urandom_range(smeu_pkg::OP_JB, smeu_pkg::OP_JAE)), pick_value(),
				3'($urandom));
		end else if (r < 89) begin
			queue_instr(smeu_pkg::OP_CALL, pick_value(), 3'($urandom));
		end else if (r < 96) begin
			queue_instr(smeu_pkg::OP_RET, pick_value(), 3'($urandom));
		end else begin
			queue_instr(5'($urandom_range(smeu_pkg::OP_RET + 1, 31)), pick_value(),
				3'($urandom));
		end
	endtask

	// Idle chance in percent for each side, by phase of the run.
	function automatic int sender_idle_pct();
		if (accepted_instrs < pending_total / 3) return 6;
		if (accepted_instrs < 2 * pending_total / 3) return 84;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (accepted_instrs < pending_total / 3) return 84;
		if (accepted_instrs < 2 * pending_total / 3) return 6;
		return 0;
	endfunction

	// Driver: presents queued instruction words and predicts each one taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid       <= 1'b0;
			cmd.func        <= '0;
			cmd.push_value  <= '0;
			cmd.reg_index   <= '0;
			cmd.target      <= '0;
			cmd.instr_index <= '0;
		end else begin
			logic   taken;
			instr_t w;
			taken = cmd.valid && cmd.ready;
			if (taken) begin
				w.func  = cmd.func;
				w.value = cmd.push_value;
				w.ridx  = cmd.reg_index;
				w.dest  = cmd.target;
				w.here  = cmd.instr_index;
				awaited_outcomes.push_back(execute_instr(w));
				void'(pending_instrs.pop_front());
				accepted_instrs++;
			end
			if (!cmd.valid || taken) begin
				if (pending_instrs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					cmd.valid       <= 1'b1;
					cmd.func        <= pending_instrs[0].func;
					cmd.push_value  <= pending_instrs[0].value;
					cmd.reg_index   <= pending_instrs[0].ridx;
					cmd.target      <= pending_instrs[0].dest;
					cmd.instr_index <= pending_instrs[0].here;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			outcome_t e;
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					report_mismatch("unexpected result word", 64'd1, 64'd0);
				end else begin
					e = awaited_outcomes.pop_front();
					if (rsp.next_index !== e.next_index)
						report_mismatch("next_index", 64'(rsp.next_index), 64'(e.next_index));
					if (rsp.jump_taken !== e.jump_taken)
						report_mismatch("jump_taken", 64'(rsp.jump_taken), 64'(e.jump_taken));
					if (rsp.top_value !== e.top_value)
						report_mismatch("top_value", rsp.top_value, e.top_value);
					if (rsp.top_valid !== e.top_valid)
						report_mismatch("top_valid", 64'(rsp.top_valid), 64'(e.top_valid));
					if (rsp.status !== e.status)
						report_mismatch("status", 64'(rsp.status), 64'(e.status));
				end
			end
			rsp.ready <= $urandom_range(0, 99) >= receiver_idle_pct();
		end
	end

	// Watchdog on cycles with no word moving on either channel.
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("stack_machine_execute_unit verification failed");
			$finish;
		end
	end

	initial begin
		gen_dcount = 0;
		gen_rcount = 0;
		arst_n     = 1'b0;

		// Directed part: faults on an empty machine, wrap and edge arithmetic.
		queue_instr(smeu_pkg::OP_OUT, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_POPREG, 64'h0, 3'd7);
		queue_instr(smeu_pkg::OP_ADD, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_SQRT, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_JB, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_RET, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_PUSH, 64'h7fff_ffff_ffff_ffff, 3'd0);
		queue_instr(smeu_pkg::OP_PUSH, 64'h1, 3'd0);
		queue_instr(smeu_pkg::OP_ADD, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_PUSH, 64'hffff_ffff_ffff_ffff, 3'd0);
		queue_instr(smeu_pkg::OP_DIV, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_PUSH, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_DIV, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_SUB, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_SQRT, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_POPREG, 64'h0, 3'd3);
		queue_instr(smeu_pkg::OP_PUSH, 64'h7fff_ffff_ffff_ffff, 3'd0);
		queue_instr(smeu_pkg::OP_SQRT, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_PUSHREG, 64'h0, 3'd3);
		queue_instr(smeu_pkg::OP_MUL, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_JMP, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_CALL, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_RET, 64'h0, 3'd0);
		queue_instr(5'd31, 64'h0, 3'd0);
		queue_instr(smeu_pkg::OP_OUT, 64'h0, 3'd0);

		while (pending_instrs.size() < RANDOM_WORDS + 25)
			queue_random_instr();
		pending_total = pending_instrs.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_instrs.size() == 0 && awaited_outcomes.size() == 0);
		repeat (100) @(posedge clk);
		if (awaited_outcomes.size() != 0)
			report_mismatch("results never arrived", 64'(awaited_outcomes.size()), 64'd0);
		if (mismatches == 0)
			$display("stack_machine_execute_unit verification clean");
		else
			$display("stack_machine_execute_unit verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/smeu_pkg.sv
sv/smeu_if.sv
sv/smeu_ram.sv
sv/smeu_iter.sv
sv/stack_machine_execute_unit.sv
verif/tb.sv
